FILE: hdl/ubq_pkg.sv
// ----------------------------------------------------------------------------
// ubq_pkg
// Shared types and codes for the buffered uart transmit/receive queue unit.
// ----------------------------------------------------------------------------
package ubq_pkg;

   // request action codes
   localparam logic [2:0] ACT_SEND    = 3'd0;
   localparam logic [2:0] ACT_TX_DONE = 3'd1;
   localparam logic [2:0] ACT_RX_BYTE = 3'd2;
   localparam logic [2:0] ACT_READ    = 3'd3;
   localparam logic [2:0] ACT_COUNT   = 3'd4;

   // response kind codes
   localparam logic [2:0] KIND_QUEUED    = 3'd0;
   localparam logic [2:0] KIND_LINE_SEND = 3'd1;
   localparam logic [2:0] KIND_WENT_IDLE = 3'd2;
   localparam logic [2:0] KIND_STORED    = 3'd3;
   localparam logic [2:0] KIND_READ_BYTE = 3'd4;
   localparam logic [2:0] KIND_READ_NONE = 3'd5;
   localparam logic [2:0] KIND_COUNT     = 3'd6;
   localparam logic [2:0] KIND_REJECTED  = 3'd7;

   // most read bytes returned for one read request
   localparam logic [3:0] MAX_RESULTS = 4'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_status_type;

endpackage

FILE: hdl/uart_buffered_tx_rx_queue_unit.sv
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_queue_unit
// Transmit ring, receive ring and busy flag for one uart channel.
// ----------------------------------------------------------------------------
//   channel   direction  handshake          payload
//   req_      in         valid / stall      action, data, read_limit
//   rsp_      out        valid / stall      kind, byte_out, ninth_bit,
//                                           fill_count, transmit_busy, last
//   csr_      in         valid / ready      data (parity_bit_enable)
//
// An item is accepted in ST_IDLE, then handled in ST_EXEC, where the ring
// memories are read (prefetched head entry) and written. A read request runs
// in ST_READ: one byte per cycle while the response is not stalled, set by the
// prefetched receive head entry, or one READ_NONE if nothing is waiting.
// A stalled response holds the sequencer; the next item is taken while the
// last response of the previous one waits. Reset is synchronous and clears
// pointers and flags at once; the ring memories get no clearing pass.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queue_unit #(
   parameter int SEND_DEPTH    = 128,
   parameter int RECEIVE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_data,
   input  logic [7:0] req_read_limit,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_ninth_bit,
   output logic [3:0] rsp_fill_count,
   output logic       rsp_transmit_busy,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   localparam int RPW = $clog2(RECEIVE_DEPTH);

   ubq_pkg::state_type       state_ff, state_in;
   logic [2:0]               act_ff;
   logic [7:0]               data_ff;
   logic [7:0]               limit_ff;
   logic [3:0]               cnt_ff, cnt_in, cnt_next;
   logic                     busy_ff, busy_in;
   logic                     parity_en_ff;

   ubq_pkg::ring_ctrl_type   send_ctrl, recv_ctrl;
   ubq_pkg::ring_status_type send_stat, recv_stat;
   logic [7:0]               send_rd, recv_rd;
   logic [$clog2(SEND_DEPTH)-1:0] send_fill;
   logic [RPW-1:0]           recv_fill;

   logic       req_accept;
   logic       out_free;
   logic       emit;
   logic [2:0] e_kind;
   logic [7:0] e_byte;
   logic       e_ninth;
   logic [3:0] e_fill;
   logic       e_last;

   logic       rsp_valid_ff;
   logic [2:0] rsp_kind_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_ninth_ff;
   logic [3:0] rsp_fill_ff;
   logic       rsp_busy_ff;
   logic       rsp_last_ff;

   ubq_ring #(.DEPTH(SEND_DEPTH)) u_send_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (send_ctrl),
      .wr_data (data_ff),
      .rd_data (send_rd),
      .status  (send_stat),
      .fill    (send_fill)
   );

   ubq_ring #(.DEPTH(RECEIVE_DEPTH)) u_recv_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (recv_ctrl),
      .wr_data (data_ff),
      .rd_data (recv_rd),
      .status  (recv_stat),
      .fill    (recv_fill)
   );

   assign req_stall  = (state_ff != ubq_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign cnt_next   = cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ubq_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         parity_en_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            parity_en_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff   <= req_action;
         data_ff  <= req_data;
         limit_ff <= req_read_limit;
      end
   end

   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      send_ctrl = '0;
      recv_ctrl = '0;
      emit      = 1'b0;
      e_kind    = ubq_pkg::KIND_QUEUED;
      e_byte    = '0;
      e_ninth   = 1'b0;
      e_fill    = '0;
      e_last    = 1'b1;
      unique case (state_ff)
         ubq_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_accept) begin
               priority if (req_action == ubq_pkg::ACT_READ) begin
                  state_in = ubq_pkg::ST_READ;
               end else if (req_action == ubq_pkg::ACT_SEND ||
                            req_action == ubq_pkg::ACT_TX_DONE ||
                            req_action == ubq_pkg::ACT_RX_BYTE ||
                            req_action == ubq_pkg::ACT_COUNT) begin
                  state_in = ubq_pkg::ST_EXEC;
               end else begin
                  // unused action codes leave no trace
                  state_in = ubq_pkg::ST_IDLE;
               end
            end
         end
         ubq_pkg::ST_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ubq_pkg::ST_IDLE;
               priority if (act_ff == ubq_pkg::ACT_SEND) begin
                  priority if (!busy_ff) begin
                     busy_in = 1'b1;
                     e_kind  = ubq_pkg::KIND_LINE_SEND;
                     e_byte  = data_ff;
                     e_ninth = parity_en_ff & ~^data_ff;
                  end else if (send_stat.full) begin
                     e_kind = ubq_pkg::KIND_REJECTED;
                  end else begin
                     send_ctrl.push = 1'b1;
                     e_kind         = ubq_pkg::KIND_QUEUED;
                  end
               end else if (act_ff == ubq_pkg::ACT_TX_DONE) begin
                  if (!send_stat.empty) begin
                     send_ctrl.pop = 1'b1;
                     e_kind        = ubq_pkg::KIND_LINE_SEND;
                     e_byte        = send_rd;
                     e_ninth       = parity_en_ff & ~^send_rd;
                  end else begin
                     busy_in = 1'b0;
                     e_kind  = ubq_pkg::KIND_WENT_IDLE;
                  end
               end else if (act_ff == ubq_pkg::ACT_RX_BYTE) begin
                  // no overflow check: a full ring wraps to empty
                  recv_ctrl.push = 1'b1;
                  e_kind         = ubq_pkg::KIND_STORED;
               end else begin
                  e_kind = ubq_pkg::KIND_COUNT;
                  e_fill = 4'(recv_fill);
               end
            end
         end
         ubq_pkg::ST_READ: begin
            if (out_free) begin
               emit = 1'b1;
               if (recv_stat.empty) begin
                  e_kind   = ubq_pkg::KIND_READ_NONE;
                  state_in = ubq_pkg::ST_IDLE;
               end else begin
                  recv_ctrl.pop = 1'b1;
                  e_kind        = ubq_pkg::KIND_READ_BYTE;
                  e_byte        = recv_rd;
                  cnt_in        = cnt_next;
                  e_last        = (recv_fill == RPW'(1)) ||
                                  (cnt_next == ubq_pkg::MAX_RESULTS) ||
                                  ({4'b0, cnt_next} == limit_ff);
                  if (e_last) begin
                     state_in = ubq_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ubq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= e_kind;
         rsp_byte_ff  <= e_byte;
         rsp_ninth_ff <= e_ninth;
         rsp_fill_ff  <= e_fill;
         rsp_busy_ff  <= busy_in;
         rsp_last_ff  <= e_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_byte_out      = rsp_byte_ff;
   assign rsp_ninth_bit     = rsp_ninth_ff;
   assign rsp_fill_count    = rsp_fill_ff;
   assign rsp_transmit_busy = rsp_busy_ff;
   assign rsp_last          = rsp_last_ff;

   // queued bytes only exist while the transmitter is busy
   assert property (@(posedge clock) disable iff (reset)
      send_ctrl.push |-> busy_ff)
      else $error("send ring push while transmitter idle");

   assert property (@(posedge clock) disable iff (reset)
      send_ctrl.pop |-> (!send_stat.empty && busy_ff))
      else $error("send ring pop while empty or idle");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == ubq_pkg::ACT_READ)) |=>
         (state_ff == ubq_pkg::ST_READ))
      else $error("read request did not start the read sequence");

   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy_ff) && !$past(reset)) |->
         ($past(act_ff) == ubq_pkg::ACT_TX_DONE && $past(send_stat.empty)))
      else $error("busy cleared without transmit done on empty ring");

   assert property (@(posedge clock) disable iff (reset)
      (emit && (state_ff == ubq_pkg::ST_READ) && !e_last) |=>
         (state_ff == ubq_pkg::ST_READ))
      else $error("read sequence ended before its last byte");

endmodule

FILE: hdl/ubq_ring.sv
// ----------------------------------------------------------------------------
// ubq_ring
// Byte ring on a synchronous memory; head entry is prefetched every cycle.
// ----------------------------------------------------------------------------
module ubq_ring #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ubq_pkg::ring_ctrl_type       ctrl,
   input  logic [7:0]                   wr_data,
   output logic [7:0]                   rd_data,
   output ubq_pkg::ring_status_type     status,
   output logic [$clog2(DEPTH)-1:0]     fill
);

   localparam int PW = $clog2(DEPTH);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
   localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [PW-1:0] head_inc, tail_inc;
   logic [PW:0]   diff;

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign head_in  = ctrl.pop  ? head_inc : head_ff;
   assign tail_in  = ctrl.push ? tail_inc : tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // read address follows the next head so rd_data always holds the head entry
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= wr_data;
      end
      if (ctrl.push && (tail_ff == head_in)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[head_in];
      end
   end

   always_comb begin
      diff = {1'b0, tail_ff} - {1'b0, head_ff};
      if (tail_ff < head_ff) begin
         diff = diff + DEPTH_W;
      end
   end

   assign rd_data      = rd_data_ff;
   assign fill         = diff[PW-1:0];
   assign status.empty = (head_ff == tail_ff);
   assign status.full  = (tail_inc == head_ff);

endmodule

FILE: test/ubq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ubq_checker
// Watches the request, response and register channels of the uart queue
// unit. Keeps its own copy of both rings, the busy flag and the parity
// setting. Builds the owed responses for each accepted request with a used code and compares
// each accepted response with the oldest one, field by field.
// ----------------------------------------------------------------------------
module ubq_checker #(
   parameter int SEND_DEPTH    = 128,
   parameter int RECEIVE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_data,
   input  logic [7:0]  req_read_limit,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_byte_out,
   input  logic        rsp_ninth_bit,
   input  logic [3:0]  rsp_fill_count,
   input  logic        rsp_transmit_busy,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int unsigned fail_count,
   output int unsigned owed_count
);

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] byte_out;
      logic       ninth_bit;
      logic [3:0] fill_count;
      logic       transmit_busy;
      logic       last;
   } uart_result_type;

   uart_result_type owed_results[$];

   logic [7:0] tx_ring [0:SEND_DEPTH-1];
   logic [7:0] rx_ring [0:RECEIVE_DEPTH-1];
   int         tx_rd, tx_wr, rx_rd, rx_wr;
   logic       tx_busy;
   logic       parity_on;

   function automatic void owe(input logic [2:0] kind, input logic [7:0] b,
                               input logic ninth, input logic [3:0] fill,
                               input logic last);
      uart_result_type r;
      r.kind          = kind;
      r.byte_out      = b;
      r.ninth_bit     = ninth;
      r.fill_count    = fill;
      r.transmit_busy = tx_busy;
      r.last          = last;
      owed_results.push_back(r);
   endfunction

   // odd parity: ninth bit set when the byte has an even number of ones
   function automatic void owe_line_send(input logic [7:0] b);
      owe(ubq_pkg::KIND_LINE_SEND, b, parity_on ? ~^b : 1'b0, 4'd0, 1'b1);
   endfunction

   task automatic advance_rings(input logic [2:0] act, input logic [7:0] dat,
                                input logic [7:0] lim);
      int avail;
      int cap;
      int n_out;
      case (act)
         ubq_pkg::ACT_SEND: begin
            if (!tx_busy) begin
               tx_busy = 1'b1;
               owe_line_send(dat);
            end else if ((tx_wr + 1) % SEND_DEPTH == tx_rd) begin
               owe(ubq_pkg::KIND_REJECTED, 8'd0, 1'b0, 4'd0, 1'b1);
            end else begin
               tx_ring[tx_wr] = dat;
               tx_wr = (tx_wr + 1) % SEND_DEPTH;
               owe(ubq_pkg::KIND_QUEUED, 8'd0, 1'b0, 4'd0, 1'b1);
            end
         end
         ubq_pkg::ACT_TX_DONE: begin
            if (tx_rd != tx_wr) begin
               owe_line_send(tx_ring[tx_rd]);
               tx_rd = (tx_rd + 1) % SEND_DEPTH;
            end else begin
               tx_busy = 1'b0;
               owe(ubq_pkg::KIND_WENT_IDLE, 8'd0, 1'b0, 4'd0, 1'b1);
            end
         end
         ubq_pkg::ACT_RX_BYTE: begin
            // no overflow check: the write side may lap the read side
            rx_ring[rx_wr] = dat;
            rx_wr = (rx_wr + 1) % RECEIVE_DEPTH;
            owe(ubq_pkg::KIND_STORED, 8'd0, 1'b0, 4'd0, 1'b1);
         end
         ubq_pkg::ACT_READ: begin
            avail = (rx_wr + RECEIVE_DEPTH - rx_rd) % RECEIVE_DEPTH;
            cap   = int'(ubq_pkg::MAX_RESULTS);
            if (lim != 8'd0 && int'(lim) < cap) cap = int'(lim);
            n_out = (avail < cap) ? avail : cap;
            if (n_out == 0) begin
               owe(ubq_pkg::KIND_READ_NONE, 8'd0, 1'b0, 4'd0, 1'b1);
            end
            for (int i = 0; i < n_out; i++) begin
               owe(ubq_pkg::KIND_READ_BYTE, rx_ring[rx_rd], 1'b0, 4'd0,
                   i == n_out - 1);
               rx_rd = (rx_rd + 1) % RECEIVE_DEPTH;
            end
         end
         ubq_pkg::ACT_COUNT: begin
            avail = (rx_wr + RECEIVE_DEPTH - rx_rd) % RECEIVE_DEPTH;
            owe(ubq_pkg::KIND_COUNT, 8'd0, 1'b0, avail[3:0], 1'b1);
         end
         default: ;  // unused codes change nothing
      endcase
   endtask

   task automatic check_result();
      uart_result_type got;
      uart_result_type want;
      got.kind          = rsp_kind;
      got.byte_out      = rsp_byte_out;
      got.ninth_bit     = rsp_ninth_bit;
      got.fill_count    = rsp_fill_count;
      got.transmit_busy = rsp_transmit_busy;
      got.last          = rsp_last;
      if (owed_results.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: response with none owed", $realtime);
            $display("%0t: got kind=%0d byte=%02h ninth=%0d fill=%0d busy=%0d last=%0d",
                     $realtime, got.kind, got.byte_out, got.ninth_bit,
                     got.fill_count, got.transmit_busy, got.last);
         end
      end else begin
         want = owed_results.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: exp kind=%0d byte=%02h ninth=%0d fill=%0d busy=%0d last=%0d",
                        $realtime, want.kind, want.byte_out, want.ninth_bit,
                        want.fill_count, want.transmit_busy, want.last);
               $display("%0t: got kind=%0d byte=%02h ninth=%0d fill=%0d busy=%0d last=%0d",
                        $realtime, got.kind, got.byte_out, got.ninth_bit,
                        got.fill_count, got.transmit_busy, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_results.delete();
         tx_rd      = 0;
         tx_wr      = 0;
         rx_rd      = 0;
         rx_wr      = 0;
         tx_busy    = 1'b0;
         parity_on  = 1'b0;
         fail_count = 0;
         owed_count <= 0;
      end else begin
         // a response never leaves on the edge that takes its own request
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) advance_rings(req_action, req_data, req_read_limit);
         if (csr_valid && csr_ready) parity_on = csr_data;
         owed_count <= owed_results.size();
      end
   end

endmodule

FILE: test/uart_buffered_tx_rx_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_queue_unit_tb
// Drives requests and parity settings into the uart queue unit with random
// gaps and response stalls: a directed pass over the corner cases, a full
// transmit ring, the longest read and a receive ring overflow.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queue_unit_tb;

   localparam int          SEND_DEPTH       = 128;
   localparam int          RECEIVE_DEPTH    = 16;
   localparam int          MAX_GAP          = 18;
   localparam int          DRAIN_CYCLES     = 20;
   localparam int          CYCLE_LIMIT      = 600000;
   localparam logic [2:0]  ACT_FIRST_UNUSED = 3'd5;
   localparam logic [2:0]  ACT_LAST_UNUSED  = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_action;
   logic [7:0]  req_data;
   logic [7:0]  req_read_limit;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_byte_out;
   logic        rsp_ninth_bit;
   logic [3:0]  rsp_fill_count;
   logic        rsp_transmit_busy;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;
   int unsigned fail_count;
   int unsigned owed_count;
   logic        quiet;
   int unsigned rsp_gap;

   uart_buffered_tx_rx_queue_unit #(
      .SEND_DEPTH    (SEND_DEPTH),
      .RECEIVE_DEPTH (RECEIVE_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_data          (req_data),
      .req_read_limit    (req_read_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_ninth_bit     (rsp_ninth_bit),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_transmit_busy (rsp_transmit_busy),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   ubq_checker #(
      .SEND_DEPTH    (SEND_DEPTH),
      .RECEIVE_DEPTH (RECEIVE_DEPTH)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_data          (req_data),
      .req_read_limit    (req_read_limit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_ninth_bit     (rsp_ninth_bit),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_transmit_busy (rsp_transmit_busy),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .owed_count        (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned pick_gap();
      return quiet ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [7:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'($urandom_range(1, 3));
         2:       return 8'(ubq_pkg::MAX_RESULTS);
         3:       return 8'(ubq_pkg::MAX_RESULTS) + 8'd1;
         4:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // response side: after each accepted response, hold stall for a gap drawn by pick_gap
   initial begin
      rsp_stall = 1'b0;
      rsp_gap   = 0;
      forever begin
         @(negedge clock);
         if (rsp_gap > 0) begin
            rsp_stall <= 1'b1;
            rsp_gap--;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) rsp_gap = pick_gap();
      end
   end

   // valid stays high after acceptance until the next item or idle point
   task automatic put_req(input logic [2:0] act, input logic [7:0] dat,
                          input logic [7:0] lim);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_data       <= dat;
      req_read_limit <= lim;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_count != 0) @(negedge clock);
      // unused codes leave nothing owed but may still be in flight
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_parity(input logic value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_valid      = 1'b0;
      req_action     = ubq_pkg::ACT_COUNT;
      req_data       = 8'd0;
      req_read_limit = 8'd0;
      csr_valid      = 1'b0;
      csr_data       = 1'b0;
      quiet          = 1'b0;
      reset          = 1'b1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed corners, parity off
      put_req(ubq_pkg::ACT_TX_DONE, 8'hff, 8'hff);
      put_req(ubq_pkg::ACT_SEND, 8'hff, 8'hff);
      put_req(ubq_pkg::ACT_SEND, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_TX_DONE, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_TX_DONE, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_RX_BYTE, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_RX_BYTE, 8'hff, 8'hff);
      put_req(ubq_pkg::ACT_RX_BYTE, 8'h5a, 8'h00);
      put_req(ubq_pkg::ACT_COUNT, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_READ, 8'h00, 8'd1);
      put_req(ubq_pkg::ACT_READ, 8'h00, 8'hff);
      put_req(ubq_pkg::ACT_READ, 8'h00, 8'h00);
      put_req(ACT_FIRST_UNUSED, 8'hff, 8'hff);
      put_req(ACT_LAST_UNUSED, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_COUNT, 8'h00, 8'h00);

      write_parity(1'b1);
      put_req(ubq_pkg::ACT_SEND, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_SEND, 8'h01, 8'h00);
      put_req(ubq_pkg::ACT_TX_DONE, 8'h00, 8'h00);

      // transmit ring: fill it, overrun it, free one slot and refill it
      repeat (SEND_DEPTH) put_req(ubq_pkg::ACT_SEND, 8'($urandom_range(0, 255)), pick_limit());
      put_req(ubq_pkg::ACT_TX_DONE, 8'($urandom_range(0, 255)), 8'h00);
      put_req(ubq_pkg::ACT_SEND, 8'($urandom_range(0, 255)), 8'h00);

      // receive ring: longest read, then overflow to empty without idling
      write_parity(1'b0);
      repeat (RECEIVE_DEPTH - 1) put_req(ubq_pkg::ACT_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
      put_req(ubq_pkg::ACT_READ, 8'h00, 8'h00);
      quiet = 1'b1;
      repeat (RECEIVE_DEPTH) put_req(ubq_pkg::ACT_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
      put_req(ubq_pkg::ACT_COUNT, 8'h00, 8'h00);
      put_req(ubq_pkg::ACT_READ, 8'h00, 8'(ubq_pkg::MAX_RESULTS) + 8'd1);
      quiet = 1'b0;

      settle();
      if (fail_count == 0 && owed_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/ubq_pkg.sv
hdl/ubq_ring.sv
hdl/uart_buffered_tx_rx_queue_unit.sv
test/ubq_checker.sv
test/uart_buffered_tx_rx_queue_unit_tb.sv
